FILE: rtl/core/asgv_pkg.sv
// Package for the alpha-snapped grid vertex block: payload structs, register map, FSM states.
// No dependencies.
`timescale 1ns / 1ps
package asgv_pkg;

  localparam int unsigned MaxWidth  = 256;
  localparam int unsigned MaxHeight = 256;
  localparam int unsigned MaxGrid   = 255;
  localparam int unsigned StoreAw   = 16;
  localparam int unsigned StoreDw   = 8;

  typedef struct packed {
    logic        cmd;
    logic [15:0] pixel_index;
    logic [7:0]  alpha_value;
    logic [7:0]  grid_x;
    logic [7:0]  grid_y;
  } in_item_t;

  typedef struct packed {
    logic [16:0] pos_x;
    logic [16:0] pos_y;
    logic [16:0] tex_u;
    logic [16:0] tex_v;
  } out_item_t;

  typedef enum logic [2:0] {
    RegWidth  = 3'd0,
    RegHeight = 3'd1,
    RegCols   = 3'd2,
    RegRows   = 3'd3,
    RegThresh = 3'd4,
    RegOk     = 3'd5
  } reg_idx_e;

  localparam logic CmdLoad  = 1'b0;
  localparam logic CmdQuery = 1'b1;

  typedef enum logic [3:0] {
    StIdle,
    StDivPx,
    StDivPy,
    StDivPosX,
    StDivPosY,
    StDivU,
    StDivV,
    StCenter,
    StScanRead,
    StScanWait,
    StSnapX,
    StSnapY,
    StDone
  } state_e;

  // divider request: numerator up to 25 bits, divisor up to 9 bits
  typedef struct packed {
    logic        start;
    logic [24:0] num;
    logic [8:0]  den;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [24:0] quo;
  } div_rsp_t;

endpackage

FILE: rtl/core/asgv_ram.sv
// Generic single-port synchronous RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
module asgv_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
    rdata_o <= mem[addr_i];
  end
endmodule

FILE: rtl/core/asgv_div.sv
// Restoring serial divider, one quotient bit per cycle.
// Depends on asgv_pkg.
`timescale 1ns / 1ps
module asgv_div (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  asgv_pkg::div_req_t  req_i,
  output asgv_pkg::div_rsp_t  rsp_o
);
  import asgv_pkg::*;

  logic [24:0] quo_q, quo_d;
  logic [9:0]  rem_q, rem_d;
  logic [8:0]  den_q, den_d;
  logic [4:0]  cnt_q, cnt_d;
  logic        busy_q, busy_d, done_q, done_d;
  logic [9:0]  trial;

  always_comb begin
    quo_d  = quo_q;
    rem_d  = rem_q;
    den_d  = den_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    trial  = {rem_q[8:0], quo_q[24]};
    if (req_i.start) begin
      quo_d  = req_i.num;
      rem_d  = '0;
      den_d  = req_i.den;
      cnt_d  = 5'd24;
      busy_d = 1'b1;
    end else if (busy_q) begin
      // shift in next numerator bit, subtract when it fits
      if (trial >= {1'b0, den_q}) begin
        rem_d = trial - {1'b0, den_q};
        quo_d = {quo_q[23:0], 1'b1};
      end else begin
        rem_d = trial;
        quo_d = {quo_q[23:0], 1'b0};
      end
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end else begin
        cnt_d = cnt_q - 5'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    den_q <= den_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quo  = quo_q;
endmodule

FILE: rtl/core/alpha_snapped_grid_vertex.sv
// Alpha-snapped grid vertex: top level with config registers, sequencer and alpha store.
// Depends on asgv_pkg, asgv_ram, asgv_div. Load: writes the alpha store, no result, busy stays low.
// Query: six serial divisions, then a center read; if RegOk is set and the center meets the
// threshold the valid_o strobe follows, else up to nine neighborhood pixels are read and a
// hit adds two more divisions (snap). Busy drops in the strobe cycle.
// Receiver cannot stall. Reset clears config and control; alpha store undefined until written.
`timescale 1ns / 1ps
module alpha_snapped_grid_vertex (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start,
  output logic                 busy,
  input  asgv_pkg::in_item_t   in_item_i,
  output logic                 valid_o,
  output asgv_pkg::out_item_t  out_item_o,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [4:0]           paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready
);
  import asgv_pkg::*;

  // configuration registers
  logic [8:0] wid_q, hei_q;
  logic [7:0] col_q, row_q, thr_q;
  logic       ok_q;
  logic       cfg_we;
  reg_idx_e   ridx;

  assign pready = 1'b1;
  assign cfg_we = psel & penable & pwrite;
  assign ridx   = reg_idx_e'(paddr[4:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wid_q <= 9'd1;
      hei_q <= 9'd1;
      col_q <= 8'd1;
      row_q <= 8'd1;
      thr_q <= '0;
      ok_q  <= 1'b0;
    end else if (cfg_we) begin
      unique case (ridx)
        RegWidth:  wid_q <= pwdata[8:0];
        RegHeight: hei_q <= pwdata[8:0];
        RegCols:   col_q <= pwdata[7:0];
        RegRows:   row_q <= pwdata[7:0];
        RegThresh: thr_q <= pwdata[7:0];
        RegOk:     ok_q  <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (ridx)
      RegWidth:  prdata = {23'd0, wid_q};
      RegHeight: prdata = {23'd0, hei_q};
      RegCols:   prdata = {24'd0, col_q};
      RegRows:   prdata = {24'd0, row_q};
      RegThresh: prdata = {24'd0, thr_q};
      RegOk:     prdata = {31'd0, ok_q};
      default:   prdata = '0;
    endcase
  end

  // saturated sizes
  logic [8:0] w, h, dxm, dym;
  logic [7:0] c, r;
  always_comb begin
    w = (wid_q == '0) ? 9'd1 : ((wid_q > 9'd256) ? 9'd256 : wid_q);
    h = (hei_q == '0) ? 9'd1 : ((hei_q > 9'd256) ? 9'd256 : hei_q);
    c = (col_q == '0) ? 8'd1 : col_q;
    r = (row_q == '0) ? 8'd1 : row_q;
    dxm = (w > 9'd1) ? w - 9'd1 : 9'd1;
    dym = (h > 9'd1) ? h - 9'd1 : 9'd1;
  end

  state_e st_q, st_d;
  logic [7:0]  gx_q, gx_d, gy_q, gy_d;
  logic [7:0]  px_q, px_d, py_q, py_d;
  logic [16:0] posx_q, posx_d, posy_q, posy_d, u_q, u_d, v_q, v_d;
  logic [7:0]  sx_q, sx_d, sy_q, sy_d, xhi_q, xhi_d, yhi_q, yhi_d, xlo_q, xlo_d;
  logic [7:0]  mul_a;
  logic [8:0]  mul_b;
  logic [16:0] prod;
  logic        vld_q, vld_d;
  div_req_t    dreq;
  div_rsp_t    drsp;
  logic        we;
  logic [15:0] addr, pix_addr;
  logic [7:0]  rdata;
  logic [7:0]  gxs, gys;
  logic [15:0] rowbase;

  assign gxs = (in_item_i.grid_x > c) ? c : in_item_i.grid_x;
  assign gys = (in_item_i.grid_y > r) ? r : in_item_i.grid_y;
  assign prod = 17'(mul_a) * 17'(mul_b);
  assign rowbase = 16'(sy_q * w);
  assign pix_addr = 16'(rowbase + 16'(sx_q));
  assign busy = (st_q != StIdle);

  asgv_ram #(.Width(StoreDw), .Depth(1 << StoreAw)) u_store (
    .clk_i  (clk_i),
    .we_i   (we),
    .addr_i (addr),
    .wdata_i(in_item_i.alpha_value),
    .rdata_o(rdata)
  );

  asgv_div u_div (.clk_i(clk_i), .rst_ni(rst_ni), .req_i(dreq), .rsp_o(drsp));

  // query sequencer
  always_comb begin
    st_d = st_q; gx_d = gx_q; gy_d = gy_q; px_d = px_q; py_d = py_q;
    posx_d = posx_q; posy_d = posy_q; u_d = u_q; v_d = v_q;
    sx_d = sx_q; sy_d = sy_q; xhi_d = xhi_q; yhi_d = yhi_q; xlo_d = xlo_q;
    vld_d = 1'b0;
    we = 1'b0;
    addr = pix_addr;
    dreq = '0;
    mul_a = gx_q;
    mul_b = w - 9'd1;
    unique case (st_q)
      StIdle: begin
        addr = in_item_i.pixel_index;
        if (start) begin
          if (in_item_i.cmd == CmdLoad) begin
            we = 1'b1;
          end else begin
            gx_d = gxs;
            gy_d = gys;
            mul_a = gxs;
            dreq.start = 1'b1;
            dreq.num = 25'(prod);
            dreq.den = {1'b0, c};
            st_d = StDivPx;
          end
        end
      end
      StDivPx: if (drsp.done) begin
        px_d = drsp.quo[7:0];
        mul_a = gy_q; mul_b = h - 9'd1;
        dreq.start = 1'b1; dreq.num = 25'(prod); dreq.den = {1'b0, r};
        st_d = StDivPy;
      end
      StDivPy: if (drsp.done) begin
        py_d = drsp.quo[7:0];
        mul_a = gx_q; mul_b = w;
        dreq.start = 1'b1; dreq.num = {prod, 8'd0}; dreq.den = {1'b0, c};
        st_d = StDivPosX;
      end
      StDivPosX: if (drsp.done) begin
        posx_d = drsp.quo[16:0];
        mul_a = gy_q; mul_b = h;
        dreq.start = 1'b1; dreq.num = {prod, 8'd0}; dreq.den = {1'b0, r};
        st_d = StDivPosY;
      end
      StDivPosY: if (drsp.done) begin
        posy_d = drsp.quo[16:0];
        dreq.start = 1'b1; dreq.num = {1'b0, gx_q, 16'd0}; dreq.den = {1'b0, c};
        st_d = StDivU;
      end
      StDivU: if (drsp.done) begin
        u_d = drsp.quo[16:0];
        dreq.start = 1'b1; dreq.num = {1'b0, gy_q, 16'd0}; dreq.den = {1'b0, r};
        // center pixel address set up for the read below
        sx_d = px_q; sy_d = py_q;
        st_d = StDivV;
      end
      StDivV: if (drsp.done) begin
        v_d = drsp.quo[16:0];
        st_d = StCenter;
      end
      StCenter: begin
        // center pixel read data comes from the registered store output
        // set neighborhood bounds; accept the center or start the scan
        xlo_d = (px_q > 8'd0) ? px_q - 8'd1 : 8'd0;
        xhi_d = (9'(px_q) + 9'd1 < w) ? px_q + 8'd1 : 8'(w - 9'd1);
        yhi_d = (9'(py_q) + 9'd1 < h) ? py_q + 8'd1 : 8'(h - 9'd1);
        sx_d = (px_q > 8'd0) ? px_q - 8'd1 : 8'd0;
        sy_d = (py_q > 8'd0) ? py_q - 8'd1 : 8'd0;
        if (ok_q && rdata >= thr_q) begin
          vld_d = 1'b1;
          st_d = StIdle;
        end else begin
          st_d = StScanRead;
        end
      end
      StScanRead: st_d = StScanWait;
      StScanWait: begin
        if (rdata >= thr_q) begin
          mul_a = sx_q; mul_b = w;
          dreq.start = 1'b1; dreq.num = {prod, 8'd0}; dreq.den = dxm;
          st_d = StSnapX;
        end else if (sx_q != xhi_q) begin
          sx_d = sx_q + 8'd1;
          st_d = StScanRead;
        end else if (sy_q != yhi_q) begin
          sx_d = xlo_q;
          sy_d = sy_q + 8'd1;
          st_d = StScanRead;
        end else begin
          st_d = StDone;
        end
      end
      StSnapX: if (drsp.done) begin
        posx_d = drsp.quo[16:0];
        mul_a = sy_q; mul_b = h;
        dreq.start = 1'b1; dreq.num = {prod, 8'd0}; dreq.den = dym;
        st_d = StSnapY;
      end
      StSnapY: if (drsp.done) begin
        posy_d = drsp.quo[16:0];
        st_d = StDone;
      end
      StDone: begin
        vld_d = 1'b1;
        st_d = StIdle;
      end
      default: st_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q  <= StIdle;
      vld_q <= 1'b0;
    end else begin
      st_q  <= st_d;
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    gx_q <= gx_d; gy_q <= gy_d; px_q <= px_d; py_q <= py_d;
    posx_q <= posx_d; posy_q <= posy_d; u_q <= u_d; v_q <= v_d;
    sx_q <= sx_d; sy_q <= sy_d; xhi_q <= xhi_d; yhi_q <= yhi_d; xlo_q <= xlo_d;
  end

  assign valid_o          = vld_q;
  assign out_item_o.pos_x = posx_q;
  assign out_item_o.pos_y = posy_q;
  assign out_item_o.tex_u = u_q;
  assign out_item_o.tex_v = v_q;
endmodule
